// ----- src/ascii_command_line_parser_top_assert.svh -----
// Assertion macros for the command line parser
`ifndef ASCII_COMMAND_LINE_PARSER_TOP_ASSERT_SVH
`define ASCII_COMMAND_LINE_PARSER_TOP_ASSERT_SVH
// checked only outside reset
`define CLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/aclp_pkg.sv -----
package aclp_pkg;

  typedef enum logic [3:0] {
    EV_BTN_SHORT = 4'd0,
    EV_BTN_LONG  = 4'd1,
    EV_BTN_OTHER = 4'd2,
    EV_HELLO     = 4'd3,
    EV_PING      = 4'd4,
    EV_I2C       = 4'd5,
    EV_TOUCH     = 4'd6,
    EV_ADC       = 4'd7,
    EV_TEMP      = 4'd8
  } ev_kind_t;

  localparam int unsigned C_BTN   = 0;
  localparam int unsigned C_HELLO = 1;
  localparam int unsigned C_PING  = 2;
  localparam int unsigned C_I2C   = 3;
  localparam int unsigned C_BOOP  = 4;
  localparam int unsigned C_ADC   = 5;
  localparam int unsigned C_TEMP  = 6;
  localparam int unsigned NCMD    = 7;

  // number flag bits
  localparam int unsigned NF_NEG  = 0;
  localparam int unsigned NF_SGN  = 1;
  localparam int unsigned NF_DIG  = 2;
  localparam int unsigned NF_STOP = 3;

  localparam logic [32:0] MAG_CAP = 33'h0_8000_0001;
  localparam logic [32:0] MAG_POS = 33'h0_7FFF_FFFF;
  localparam logic [32:0] MAG_NEG = 33'h0_8000_0000;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef logic [7:0] text_t [0:7];

  localparam text_t CMD_TEXT [0:NCMD-1] = '{
    '{8'h42, 8'h54, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // BTN
    '{8'h48, 8'h45, 8'h4C, 8'h4C, 8'h4F, 8'h00, 8'h00, 8'h00},  // HELLO
    '{8'h50, 8'h49, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},  // PING
    '{8'h49, 8'h32, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // I2C
    '{8'h42, 8'h4F, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00},  // BOOP
    '{8'h41, 8'h44, 8'h43, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // ADC
    '{8'h54, 8'h45, 8'h4D, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00}   // TEMP
  };
  localparam logic [4:0] CMD_LEN [0:NCMD-1] = '{5'd3, 5'd5, 5'd4, 5'd3, 5'd4, 5'd3, 5'd4};

  localparam text_t WORD_TEXT [0:2] = '{
    '{8'h53, 8'h48, 8'h4F, 8'h52, 8'h54, 8'h00, 8'h00, 8'h00},  // SHORT
    '{8'h4C, 8'h4F, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},  // LONG
    '{8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // "1"
  };
  localparam logic [4:0] WORD_LEN [0:2] = '{5'd5, 5'd4, 5'd1};

  typedef struct packed {
    logic [32:0] mag;
    logic [3:0]  flags;
  } num_t;

  function automatic num_t num_feed(input logic [32:0] mag, input logic [3:0] f,
                                    input logic [7:0] c);
    num_t        r;
    logic [36:0] t;
    r.mag   = mag;
    r.flags = f;
    t       = {mag, 3'b000} + {2'b00, mag, 1'b0} + {33'd0, c[3:0]};
    if (!f[NF_STOP]) begin
      if (!(f[NF_DIG] | f[NF_SGN]) && (c == 8'h09 || c == 8'h0B || c == 8'h0C)) begin
        r.flags = f;
      end else if (!(f[NF_DIG] | f[NF_SGN]) && (c == 8'h2B || c == 8'h2D)) begin
        r.flags[NF_SGN] = 1'b1;
        if (c == 8'h2D) r.flags[NF_NEG] = 1'b1;
      end else if (c >= 8'h30 && c <= 8'h39) begin
        r.flags[NF_DIG] = 1'b1;
        r.mag = (t > {4'd0, MAG_CAP}) ? MAG_CAP : t[32:0];
      end else begin
        r.flags[NF_STOP] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic num_ok(input logic [32:0] mag, input logic [3:0] f);
    return f[NF_DIG] && (mag <= (f[NF_NEG] ? MAG_NEG : MAG_POS));
  endfunction

  // range check for 0..hi
  function automatic logic num_in(input logic [32:0] mag, input logic [3:0] f,
                                  input logic [32:0] hi);
    return num_ok(mag, f) && (f[NF_NEG] ? (mag == 33'd0) : (mag <= hi));
  endfunction

  function automatic logic [31:0] num_value(input logic [32:0] mag, input logic [3:0] f);
    return f[NF_NEG] ? (32'd0 - mag[31:0]) : mag[31:0];
  endfunction

  typedef struct packed {
    logic       ok;
    logic [3:0] d;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r.ok = 1'b1;
    r.d  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39)      r.d = c[3:0];
    else if (c >= 8'h61 && c <= 8'h66) r.d = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) r.d = 4'(c - 8'h37);
    else                                r.ok = 1'b0;
    return r;
  endfunction

endpackage

// ----- src/ascii_command_line_parser_top.sv -----
// Latency: an event word is valid the cycle after its CR/LF is accepted.
// Throughput: one byte per cycle while in_ready is high; all token state updates are made as the byte is accepted.
// The output register frees the input as soon as the pending word is taken.
// Reset (rst_n low, synchronous) clears the line state and the output valid;
// no clearing pass is needed.
module ascii_command_line_parser_top #(
  parameter int MAX_LINE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_kind,
  output logic [30:0] out_item_index,
  output logic [31:0] out_item_value,
  output logic [63:0] out_sensor_rom,
  output logic [4:0]  out_sensor_rom_digits
);
  import aclp_pkg::*;

  localparam int LW = $clog2(MAX_LINE + 1);

  logic [LW-1:0] ln_r, ln_nxt;
  logic [2:0]    tn_r, tn_nxt;
  logic          it_r, it_nxt;
  logic [4:0]    pos_r, pos_nxt;
  logic [NCMD-1:0] cm_r, cm_nxt;
  logic [2:0]    wm_r, wm_nxt;
  logic [32:0]   n1_r, n1_nxt, n2_r, n2_nxt;
  logic [7:0]    nf_r, nf_nxt;
  logic [63:0]   rom_r, rom_nxt;
  logic [4:0]    rl_r, rl_nxt;
  logic          inv_r, inv_nxt;

  logic          ov_r;
  logic [3:0]    kind_r, kind_nxt;
  logic [30:0]   idx_r, idx_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [63:0]   orom_r, orom_nxt;
  logic [4:0]    odig_r, odig_nxt;
  logic          emit;

  logic acc;
  assign in_ready = !ov_r || out_ready;
  assign acc      = in_valid && in_ready;

  always_comb begin
    logic [7:0] c;
    logic       is_term, clr, do_end, do_feed;
    logic [2:0] need;
    num_t       nr;
    hex_t       hx;
    c        = in_rx_byte;
    ln_nxt   = ln_r;
    tn_nxt   = tn_r;
    it_nxt   = it_r;
    pos_nxt  = pos_r;
    cm_nxt   = cm_r;
    wm_nxt   = wm_r;
    n1_nxt   = n1_r;
    n2_nxt   = n2_r;
    nf_nxt   = nf_r;
    rom_nxt  = rom_r;
    rl_nxt   = rl_r;
    inv_nxt  = inv_r;
    emit     = 1'b0;
    kind_nxt = EV_HELLO;
    idx_nxt  = '0;
    val_nxt  = '0;
    orom_nxt = '0;
    odig_nxt = '0;
    need     = 3'd1;
    is_term  = (c == CH_LF) || (c == CH_CR);
    clr      = 1'b0;
    do_end   = 1'b0;
    do_feed  = 1'b0;
    nr       = '0;
    hx       = hex_digit(c);

    if (acc) begin
      if (is_term) begin
        if (ln_r != '0) begin
          do_end = it_r;
          clr    = 1'b1;
        end
      end else if (ln_r >= LW'(MAX_LINE)) begin
        clr = 1'b1;
      end else begin
        ln_nxt = ln_r + LW'(1);
        if (c == CH_SPACE) begin
          do_end = it_r;
        end else begin
          do_feed = 1'b1;
          if (!it_r) begin
            it_nxt  = 1'b1;
            pos_nxt = '0;
            if (tn_r == 3'd2) wm_nxt = 3'b111;
          end
        end
      end
    end

    if (do_feed) begin
      unique case (tn_nxt)
        3'd0: begin
          for (int k = 0; k < NCMD; k++)
            if (pos_nxt >= CMD_LEN[k] || CMD_TEXT[k][pos_nxt[2:0]] != c) cm_nxt[k] = 1'b0;
        end
        3'd1: begin
          if (cm_nxt[C_BTN] || cm_nxt[C_BOOP] || cm_nxt[C_ADC]) begin
            nr = num_feed(n1_nxt, nf_nxt[3:0], c);
            n1_nxt = nr.mag;
            nf_nxt[3:0] = nr.flags;
          end else if (cm_nxt[C_TEMP]) begin
            if (!hx.ok || rl_nxt >= 5'd16) inv_nxt = 1'b1;
            else rom_nxt = {rom_nxt[59:0], hx.d};
            if (rl_nxt < 5'd31) rl_nxt = rl_nxt + 5'd1;
          end
        end
        3'd2: begin
          if (cm_nxt[C_BTN] || cm_nxt[C_BOOP]) begin
            for (int k = 0; k < 3; k++)
              if (pos_nxt >= WORD_LEN[k] || WORD_TEXT[k][pos_nxt[2:0]] != c)
                wm_nxt[k] = 1'b0;
          end else if (cm_nxt[C_TEMP]) begin
            nr = num_feed(n2_nxt, nf_nxt[7:4], c);
            n2_nxt = nr.mag;
            nf_nxt[7:4] = nr.flags;
          end
        end
        3'd3: begin
          if (cm_nxt[C_ADC]) begin
            nr = num_feed(n2_nxt, nf_nxt[7:4], c);
            n2_nxt = nr.mag;
            nf_nxt[7:4] = nr.flags;
          end
        end
        default: ;
      endcase
      if (pos_nxt < 5'd31) pos_nxt = pos_nxt + 5'd1;
    end

    if (do_end) begin
      unique case (tn_nxt)
        3'd0: begin
          for (int k = 0; k < NCMD; k++)
            if (CMD_LEN[k] != pos_nxt) cm_nxt[k] = 1'b0;
          if (cm_nxt == '0) inv_nxt = 1'b1;
        end
        3'd1: begin
          if (cm_nxt[C_BTN] && !num_in(n1_nxt, nf_nxt[3:0], MAG_POS)) inv_nxt = 1'b1;
          if (cm_nxt[C_BOOP] && !num_in(n1_nxt, nf_nxt[3:0], 33'd11)) inv_nxt = 1'b1;
          if (cm_nxt[C_ADC] && !num_in(n1_nxt, nf_nxt[3:0], 33'd2)) inv_nxt = 1'b1;
          if (cm_nxt[C_TEMP] && (rl_nxt < 5'd1 || rl_nxt > 5'd16)) inv_nxt = 1'b1;
        end
        3'd2: begin
          if (cm_nxt[C_BTN] || cm_nxt[C_BOOP])
            for (int k = 0; k < 3; k++)
              if (WORD_LEN[k] != pos_nxt) wm_nxt[k] = 1'b0;
          if (cm_nxt[C_TEMP] && !num_ok(n2_nxt, nf_nxt[7:4])) inv_nxt = 1'b1;
        end
        3'd3: begin
          if (cm_nxt[C_ADC] && !num_in(n2_nxt, nf_nxt[7:4], 33'd5000)) inv_nxt = 1'b1;
        end
        default: ;
      endcase
      if (tn_nxt < 3'd7) tn_nxt = tn_nxt + 3'd1;
      it_nxt = 1'b0;
    end

    // event on a terminated, non-empty line
    if (clr && is_term) begin
      emit = 1'b1;
      unique case (cm_nxt)
        NCMD'(1 << C_BTN): begin
          need     = 3'd3;
          kind_nxt = wm_nxt[0] ? EV_BTN_SHORT : (wm_nxt[1] ? EV_BTN_LONG : EV_BTN_OTHER);
          idx_nxt  = n1_nxt[30:0];
        end
        NCMD'(1 << C_HELLO): kind_nxt = EV_HELLO;
        NCMD'(1 << C_PING):  kind_nxt = EV_PING;
        NCMD'(1 << C_I2C):   kind_nxt = EV_I2C;
        NCMD'(1 << C_BOOP): begin
          need     = 3'd3;
          kind_nxt = EV_TOUCH;
          idx_nxt  = n1_nxt[30:0];
          val_nxt  = {31'd0, wm_nxt[2]};
        end
        NCMD'(1 << C_ADC): begin
          need     = 3'd4;
          kind_nxt = EV_ADC;
          idx_nxt  = n1_nxt[30:0];
          val_nxt  = num_value(n2_nxt, nf_nxt[7:4]);
        end
        NCMD'(1 << C_TEMP): begin
          need     = 3'd3;
          kind_nxt = EV_TEMP;
          val_nxt  = num_value(n2_nxt, nf_nxt[7:4]);
          orom_nxt = rom_nxt;
          odig_nxt = rl_nxt;
        end
        default: emit = 1'b0;
      endcase
      if (inv_nxt || tn_nxt == 3'd0 || tn_nxt < need) emit = 1'b0;
    end

    if (clr) begin
      ln_nxt  = '0;
      tn_nxt  = '0;
      it_nxt  = 1'b0;
      pos_nxt = '0;
      cm_nxt  = '1;
      wm_nxt  = '0;
      n1_nxt  = '0;
      n2_nxt  = '0;
      nf_nxt  = '0;
      rom_nxt = '0;
      rl_nxt  = '0;
      inv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ln_r  <= '0;
      tn_r  <= '0;
      it_r  <= 1'b0;
      pos_r <= '0;
      cm_r  <= '1;
      wm_r  <= '0;
      n1_r  <= '0;
      n2_r  <= '0;
      nf_r  <= '0;
      rom_r <= '0;
      rl_r  <= '0;
      inv_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      ln_r  <= ln_nxt;
      tn_r  <= tn_nxt;
      it_r  <= it_nxt;
      pos_r <= pos_nxt;
      cm_r  <= cm_nxt;
      wm_r  <= wm_nxt;
      n1_r  <= n1_nxt;
      n2_r  <= n2_nxt;
      nf_r  <= nf_nxt;
      rom_r <= rom_nxt;
      rl_r  <= rl_nxt;
      inv_r <= inv_nxt;
      if (emit)           ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= kind_nxt;
      idx_r  <= idx_nxt;
      val_r  <= val_nxt;
      orom_r <= orom_nxt;
      odig_r <= odig_nxt;
    end
  end

  assign out_valid             = ov_r;
  assign out_event_kind        = kind_r;
  assign out_item_index        = idx_r;
  assign out_item_value        = val_r;
  assign out_sensor_rom        = orom_r;
  assign out_sensor_rom_digits = odig_r;

endmodule

// ----- src/aclp_checker.sv -----
`include "ascii_command_line_parser_top_assert.svh"
module aclp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_event_kind,
  input logic [4:0]  out_sensor_rom_digits
);
  import aclp_pkg::*;

  `CLP_ASSERT_ALWAYS(a_rst_clears_out, !rst_n |=> !out_valid, "out_valid after reset")
  `CLP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_event_kind), "stalled word changed")
  `CLP_ASSERT(a_kind_range, out_valid |-> out_event_kind <= EV_TEMP, "event kind out of range")
  `CLP_ASSERT(a_temp_digits, out_valid && out_event_kind == EV_TEMP |-> out_sensor_rom_digits >= 5'd1 && out_sensor_rom_digits <= 5'd16, "bad rom digit count")
  `CLP_ASSERT(a_other_digits, out_valid && out_event_kind != EV_TEMP |-> out_sensor_rom_digits == 5'd0, "rom digits on non temp event")

endmodule

bind ascii_command_line_parser_top aclp_checker u_aclp_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_event_kind        (out_event_kind),
  .out_sensor_rom_digits (out_sensor_rom_digits)
);

// ----- tb/sv/aclp_checker.sv -----
`timescale 1ns / 100ps
module aclp_scoreboard
  import aclp_pkg::*;
#(
  parameter int MAX_LINE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_event_kind,
  input  logic [30:0] out_item_index,
  input  logic [31:0] out_item_value,
  input  logic [63:0] out_sensor_rom,
  input  logic [4:0]  out_sensor_rom_digits,
  output int          fail_count,
  output int          pending_events
);

  typedef struct packed {
    logic [3:0]  kind;
    logic [30:0] index;
    logic [31:0] value;
    logic [63:0] rom;
    logic [4:0]  digits;
  } event_t;

  event_t event_q[$];

  // line parser state
  int unsigned line_len;
  int unsigned tok_num;
  bit          in_tok;
  int unsigned tok_pos;
  logic [6:0]  cmd_mask;
  logic [2:0]  word_mask;
  logic [32:0] num_a, num_b;
  logic [3:0]  flg_a, flg_b;
  logic [63:0] rom_acc;
  int unsigned rom_len;
  bit          bad_line;

  assign pending_events = event_q.size();

  function automatic logic [7:0] char_at(text_t t, int unsigned p);
    return p < 8 ? t[p] : 8'h00;
  endfunction

  task automatic line_clear();
    line_len = 0; tok_num = 0; in_tok = 0; tok_pos = 0;
    cmd_mask = '1; word_mask = '0;
    num_a = '0; num_b = '0; flg_a = '0; flg_b = '0;
    rom_acc = '0; rom_len = 0; bad_line = 0;
  endtask

  task automatic dec_feed(inout logic [32:0] mag, inout logic [3:0] f, input logic [7:0] c);
    logic [36:0] t;
    if (f[NF_STOP]) return;
    if (!(f[NF_DIG] | f[NF_SGN]) && (c == 8'h09 || c == 8'h0B || c == 8'h0C)) begin
    end else if (!(f[NF_DIG] | f[NF_SGN]) && (c == "+" || c == "-")) begin
      f[NF_SGN] = 1;
      if (c == "-") f[NF_NEG] = 1;
    end else if (c >= "0" && c <= "9") begin
      f[NF_DIG] = 1;
      t = 37'(mag) * 10 + 37'(c - "0");
      mag = (t > 37'(MAG_CAP)) ? MAG_CAP : t[32:0];
    end else begin
      f[NF_STOP] = 1;
    end
  endtask

  function automatic bit dec_ok(logic [32:0] mag, logic [3:0] f);
    return f[NF_DIG] && mag <= (f[NF_NEG] ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF);
  endfunction

  function automatic bit dec_range(logic [32:0] mag, logic [3:0] f, longint hi);
    longint v;
    if (!dec_ok(mag, f)) return 0;
    v = f[NF_NEG] ? -longint'(mag) : longint'(mag);
    return v >= 0 && v <= hi;
  endfunction

  function automatic logic [31:0] dec_val(logic [32:0] mag, logic [3:0] f);
    return f[NF_NEG] ? 32'd0 - mag[31:0] : mag[31:0];
  endfunction

  task automatic take_char(logic [7:0] c);
    int d;
    if (tok_num == 0) begin
      for (int k = 0; k < NCMD; k++)
        if (tok_pos >= CMD_LEN[k] || char_at(CMD_TEXT[k], tok_pos) != c) cmd_mask[k] = 0;
    end else if (tok_num == 1) begin
      if (cmd_mask[C_BTN] | cmd_mask[C_BOOP] | cmd_mask[C_ADC]) begin
        dec_feed(num_a, flg_a, c);
      end else if (cmd_mask[C_TEMP]) begin
        if (c >= "0" && c <= "9") d = c - "0";
        else if (c >= "a" && c <= "f") d = c - "a" + 10;
        else if (c >= "A" && c <= "F") d = c - "A" + 10;
        else d = -1;
        if (d < 0 || rom_len >= 16) bad_line = 1;
        else rom_acc = {rom_acc[59:0], 4'(d)};
        if (rom_len < 31) rom_len++;
      end
    end else if (tok_num == 2) begin
      if (cmd_mask[C_BTN] | cmd_mask[C_BOOP]) begin
        for (int k = 0; k < 3; k++)
          if (tok_pos >= WORD_LEN[k] || char_at(WORD_TEXT[k], tok_pos) != c) word_mask[k] = 0;
      end else if (cmd_mask[C_TEMP]) begin
        dec_feed(num_b, flg_b, c);
      end
    end else if (tok_num == 3 && cmd_mask[C_ADC]) begin
      dec_feed(num_b, flg_b, c);
    end
  endtask

  task automatic close_token();
    if (tok_num == 0) begin
      for (int k = 0; k < NCMD; k++) if (CMD_LEN[k] != tok_pos) cmd_mask[k] = 0;
      if (cmd_mask == 0) bad_line = 1;
    end else if (tok_num == 1) begin
      if (cmd_mask[C_BTN] && !dec_range(num_a, flg_a, 64'sd2147483647)) bad_line = 1;
      if (cmd_mask[C_BOOP] && !dec_range(num_a, flg_a, 11)) bad_line = 1;
      if (cmd_mask[C_ADC] && !dec_range(num_a, flg_a, 2)) bad_line = 1;
      if (cmd_mask[C_TEMP] && (rom_len < 1 || rom_len > 16)) bad_line = 1;
    end else if (tok_num == 2) begin
      if (cmd_mask[C_BTN] | cmd_mask[C_BOOP])
        for (int k = 0; k < 3; k++) if (WORD_LEN[k] != tok_pos) word_mask[k] = 0;
      if (cmd_mask[C_TEMP] && !dec_ok(num_b, flg_b)) bad_line = 1;
    end else if (tok_num == 3) begin
      if (cmd_mask[C_ADC] && !dec_range(num_b, flg_b, 5000)) bad_line = 1;
    end
    if (tok_num < 7) tok_num++;
    in_tok = 0;
  endtask

  task automatic finish_line();
    event_t e;
    int unsigned need;
    e = '0;
    need = 99;
    if (!bad_line && tok_num != 0) begin
      if (cmd_mask == 7'(1 << C_BTN)) begin
        need = 3; e.index = num_a[30:0];
        e.kind = word_mask[0] ? EV_BTN_SHORT : (word_mask[1] ? EV_BTN_LONG : EV_BTN_OTHER);
      end else if (cmd_mask == 7'(1 << C_HELLO)) begin
        need = 1; e.kind = EV_HELLO;
      end else if (cmd_mask == 7'(1 << C_PING)) begin
        need = 1; e.kind = EV_PING;
      end else if (cmd_mask == 7'(1 << C_I2C)) begin
        need = 1; e.kind = EV_I2C;
      end else if (cmd_mask == 7'(1 << C_BOOP)) begin
        need = 3; e.kind = EV_TOUCH; e.index = num_a[30:0]; e.value = word_mask[2] ? 1 : 0;
      end else if (cmd_mask == 7'(1 << C_ADC)) begin
        need = 4; e.kind = EV_ADC; e.index = num_a[30:0]; e.value = dec_val(num_b, flg_b);
      end else if (cmd_mask == 7'(1 << C_TEMP)) begin
        need = 3; e.kind = EV_TEMP; e.value = dec_val(num_b, flg_b);
        e.rom = rom_acc; e.digits = 5'(rom_len);
      end
      if (tok_num >= need) event_q = {event_q, e};
    end
  endtask

  task automatic parse_byte(logic [7:0] c);
    if (c == CH_LF || c == CH_CR) begin
      if (line_len == 0) return;
      if (in_tok) close_token();
      finish_line();
      line_clear();
      return;
    end
    if (line_len >= MAX_LINE) begin
      line_clear();
      return;
    end
    line_len++;
    if (c == CH_SPACE) begin
      if (in_tok) close_token();
      return;
    end
    if (!in_tok) begin
      in_tok = 1; tok_pos = 0;
      if (tok_num == 2) word_mask = '1;
    end
    take_char(c);
    if (tok_pos < 31) tok_pos++;
  endtask

  always @(posedge clk) begin
    event_t got, want;
    if (!rst_n) begin
      line_clear();
      event_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_event_kind, out_item_index, out_item_value, out_sensor_rom,
               out_sensor_rom_digits};
        if (event_q.size() == 0) begin
          $display("%0t: unexpected event word: %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = event_q.pop_front();
          if (got !== want) begin
            $display("%0t: event mismatch: exp kind %0d idx %0d val %0d rom %h dig %0d",
                     $realtime, want.kind, want.index, $signed(want.value), want.rom,
                     want.digits);
            $display("%0t:                 got kind %0d idx %0d val %0d rom %h dig %0d",
                     $realtime, got.kind, got.index, $signed(got.value), got.rom, got.digits);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) parse_byte(in_rx_byte);
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import aclp_pkg::*;

  localparam int MAX_LINE = 256;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  out_event_kind;
  logic [30:0] out_item_index;
  logic [31:0] out_item_value;
  logic [63:0] out_sensor_rom;
  logic [4:0]  out_sensor_rom_digits;
  int          fail_count;
  int          pending_events;
  bit          feed_done;

  ascii_command_line_parser_top #(.MAX_LINE(MAX_LINE)) u_dut (.*);

  aclp_scoreboard #(.MAX_LINE(MAX_LINE)) u_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side stalls
  initial begin
    int g;
    out_ready = 0;
    @(posedge clk iff rst_n);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_byte(logic [7:0] b);
    int g;
    g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid   <= 1;
    in_rx_byte <= b;
    @(posedge clk iff in_ready);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string rand_dec(int unsigned hi);
    string s;
    int r;
    r = $urandom_range(0, 15);
    s = "";
    if (r == 0) s = "-";
    else if (r == 1) s = "+";
    else if (r == 2) s = "\t";
    if (r == 3) return {s, "99999999999"};
    if (r == 4) return {s, $sformatf("%0d", $urandom())};
    if (r == 5) return {s, "2147483648"};
    if (r == 6) return {s, "12x"};
    return {s, $sformatf("%0d", $urandom_range(0, hi))};
  endfunction

  function automatic string rand_hex();
    string s;
    int n;
    int k;
    string dig;
    dig = "0123456789abcdefABCDEF";
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 18) : $urandom_range(1, 16);
    s = "";
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 21);
      s = {s, dig.substr(k, k)};
    end
    if ($urandom_range(0, 15) == 0) s = {s, "g"};
    return s;
  endfunction

  function automatic string rand_noise(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, 8'($urandom_range(0, 255))};
    return s;
  endfunction

  function automatic string rand_line();
    string sp, term;
    int r;
    sp = ($urandom_range(0, 7) == 0) ? "  " : " ";
    term = $urandom_range(0, 1) ? "\n" : "\r";
    r = $urandom_range(0, 19);
    case (r)
      0, 1: return {"BTN", sp, rand_dec(100000), sp,
                    ($urandom_range(0, 2) == 0) ? "SHORT" :
                    ($urandom_range(0, 1) ? "LONG" : "LONGX"), term};
      2:  return {"HELLO", ($urandom_range(0, 1) ? " junk" : ""), term};
      3:  return {"PING", term};
      4:  return {"I2C", sp, rand_noise(3), term};
      5, 6: return {"BOOP", sp, rand_dec(13), sp,
                    $urandom_range(0, 1) ? "1" : ($urandom_range(0, 1) ? "0" : "11"), term};
      7, 8: return {"ADC", sp, rand_dec(3), sp, rand_dec(9999), sp, rand_dec(5200), term};
      9, 10: return {"TEMP", sp, rand_hex(), sp, rand_dec(90000), term};
      11: return {"BTN 7", term};
      12: return {"TEM", term};
      13: return {" ", term};
      14: return {rand_noise($urandom_range(1, 12)), term};
      15: return {"ADC 1 2", term};
      16: return {"HELLOX", term};
      17: return {"BOOP 3 1 extra words", term};
      default: return {"PING", sp, rand_noise($urandom_range(0, 6)), term};
    endcase
  endfunction

  initial begin
    string s;
    int sent;
    rst_n      = 0;
    in_valid   = 0;
    in_rx_byte = 8'h00;
    feed_done  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed lines
    send_text("\n\r");
    send_text("HELLO\n");
    send_text("PING\r");
    send_text("I2C reply\n");
    send_text("BTN 0 SHORT\n");
    send_text("BTN 2147483647 LONG\r");
    send_text("BTN +5 other\n");
    send_text("BTN -0 SHORT\n");
    send_text("BTN 2147483648 SHORT\n");
    send_text("BOOP 11 1\n");
    send_text("BOOP 12 1\n");
    send_text("BOOP \t\v\f3 0\n");
    send_text("ADC 2 x 5000\n");
    send_text("ADC 0 1 5001\n");
    send_text("ADC 1 1 -2147483648\n");
    send_text("TEMP FFFFFFFFFFFFFFFF -2147483648\n");
    send_text("TEMP 0aB 2147483647\n");
    send_text("TEMP 00000000000000000 5\n");
    send_text("TEMP 1\n");
    send_text("   \n");
    send_text({"PING", 8'h00, "\n"});
    send_text({8'hFF, 8'h80, "\n"});
    s = "HELLO ";
    while (s.len() < MAX_LINE) s = {s, "A"};
    send_text({s, "\n"});
    send_text({s, "B", "HELLO\n"});

    // directed part is about 800 bytes; random lines then add at least 600 bytes more
    sent = 0;
    while (sent < 600) begin
      if ($urandom_range(0, 49) == 0) begin
        s = "PING ";
        while (s.len() < MAX_LINE + $urandom_range(0, 2)) s = {s, "x"};
        s = {s, "\n"};
      end else begin
        s = rand_line();
      end
      send_text(s);
      sent += s.len();
    end
    in_valid <= 0;
    feed_done = 1;
  end

  initial begin
    @(posedge clk iff feed_done);
    while (pending_events != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
